[rtl/hsn_pkg.sv]
// ----------------------------------------------------------------------------
// hsn_pkg
// Shared types and constants of the heightmap surface normal pipeline.
// ----------------------------------------------------------------------------
package hsn_pkg;

  localparam int HeightBits = 16;
  localparam int NumLanes   = 8;
  localparam int SqStages   = 32;  // one root bit per stage
  localparam int DivStages  = 31;  // one quotient bit per stage
  localparam int NumBits    = 62;  // dividend width
  // stage regs, squares, sum, root, numerator, quotient, weighting
  localparam int LaneLat    = 3 + SqStages + 1 + DivStages + 1;

  localparam logic [13:0] WCard = 14'd9830;  // 0.15 in Q.16
  localparam logic [13:0] WDiag = 14'd6554;  // 0.10 in Q.16

  typedef struct packed {
    logic signed [HeightBits:0] dx;
    logic signed [HeightBits:0] dz;
    logic                       two;   // up term is 2.0 instead of 1.0
    logic                       diag;  // diagonal weight
  } lane_in_t;

  typedef struct packed {
    logic signed [2:0][45:0] w;  // weighted unit components, Q.46
    logic signed [2:0][31:0] u;  // unit components, Q.30
  } lane_out_t;

endpackage

[rtl/hsn_isqrt.sv]
// ----------------------------------------------------------------------------
// hsn_isqrt
// Pipelined floor square root of a 64-bit word, one root bit per stage.
// ----------------------------------------------------------------------------
module hsn_isqrt
  import hsn_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  output logic [31:0] root_o
);

  logic [63:0] v_q [SqStages];
  logic [63:0] r_q [SqStages];

  for (genvar k = 0; k < SqStages; k++) begin : g_stage
    logic [63:0] v_in, r_in, bitv, v_d, r_d;
    logic [64:0] t;
    if (k == 0) begin : g_first
      assign v_in = x_i;
      assign r_in = '0;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = r_q[k-1];
    end
    assign bitv = 64'(1) << (62 - 2 * k);
    assign t    = {1'b0, r_in} + {1'b0, bitv};
    always_comb begin
      if ({1'b0, v_in} >= t) begin
        v_d = v_in - t[63:0];
        r_d = (r_in >> 1) + bitv;
      end else begin
        v_d = v_in;
        r_d = r_in >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k] <= v_d;
        r_q[k] <= r_d;
      end
    end
  end

  assign root_o = r_q[SqStages-1][31:0];

endmodule

[rtl/hsn_div.sv]
// ----------------------------------------------------------------------------
// hsn_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module hsn_div
  import hsn_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NumBits-1:0]   num_i,
  input  logic [31:0]          den_i,
  output logic [DivStages-1:0] quo_o
);

  logic [NumBits-1:0]   rem_q [DivStages];
  logic [DivStages-1:0] quo_q [DivStages];
  logic [31:0]          den_q [DivStages];

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    localparam int J = DivStages - 1 - s;
    logic [NumBits-1:0]   rem_in, rem_d;
    logic [DivStages-1:0] quo_in, quo_d;
    logic [31:0]          den_in;
    logic [NumBits:0]     dsh;
    if (s == 0) begin : g_first
      assign rem_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end
    assign dsh = (NumBits+1)'(den_in) << J;
    always_comb begin
      if ({1'b0, rem_in} >= dsh) begin
        rem_d = rem_in - dsh[NumBits-1:0];
        quo_d = quo_in | (DivStages'(1) << J);
      end else begin
        rem_d = rem_in;
        quo_d = quo_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        den_q[s] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DivStages-1];

endmodule

[rtl/hsn_lane.sv]
// ----------------------------------------------------------------------------
// hsn_lane
// One directional normal: scale, normalize to a unit vector, apply weight.
// ----------------------------------------------------------------------------
module hsn_lane
  import hsn_pkg::*;
(
  input  logic      clk_i,
  input  logic      en_i,
  input  logic [15:0] vscale_i,
  input  lane_in_t  lane_i,
  output lane_out_t lane_o
);

  typedef struct packed {
    logic [30:0] mx;
    logic [17:0] my;
    logic [30:0] mz;
    logic        nx;
    logic        nz;
    logic        diag;
  } side_t;

  typedef struct packed {
    logic nx;
    logic nz;
    logic diag;
  } sign_t;

  // scaled magnitudes
  logic [HeightBits:0] ax, az;
  logic [31:0] mx1_q, mz1_q;
  logic        nx1_q, nz1_q, two1_q, diag1_q;

  assign ax = lane_i.dx[HeightBits] ? (HeightBits+1)'(-lane_i.dx) : lane_i.dx;
  assign az = lane_i.dz[HeightBits] ? (HeightBits+1)'(-lane_i.dz) : lane_i.dz;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx1_q   <= ax[15:0] * vscale_i;
      mz1_q   <= az[15:0] * vscale_i;
      nx1_q   <= lane_i.dx[HeightBits];
      nz1_q   <= lane_i.dz[HeightBits];
      two1_q  <= lane_i.two;
      diag1_q <= lane_i.diag;
    end
  end

  // drop one bit when a magnitude reaches 2^31, then square
  logic        sh;
  logic [30:0] mx2, mz2;
  logic [17:0] my2;
  logic [63:0] sqy2;
  logic [61:0] sqx2_q, sqz2_q;
  logic [63:0] sqy2_q;
  side_t       s2_q, s3_q;
  logic [63:0] sum3_q;

  assign sh  = mx1_q[31] | mz1_q[31];
  assign mx2 = sh ? mx1_q[31:1] : mx1_q[30:0];
  assign mz2 = sh ? mz1_q[31:1] : mz1_q[30:0];
  assign my2 = (two1_q ? 18'h20000 : 18'h10000) >> sh;
  assign sqy2 = 64'(1) << (32 + (two1_q ? 2 : 0) - (sh ? 2 : 0));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqx2_q <= mx2 * mx2;
      sqz2_q <= mz2 * mz2;
      sqy2_q <= sqy2;
      s2_q   <= '{mx: mx2, my: my2, mz: mz2, nx: nx1_q, nz: nz1_q, diag: diag1_q};
      sum3_q <= 64'(sqx2_q) + 64'(sqz2_q) + sqy2_q;
      s3_q   <= s2_q;
    end
  end

  // length
  logic [31:0] root;
  side_t       side_q [SqStages];

  hsn_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en_i),
    .x_i    (sum3_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= s3_q;
      for (int k = 1; k < SqStages; k++) side_q[k] <= side_q[k-1];
    end
  end

  // dividends with half-length rounding
  side_t              sl;
  logic [NumBits-1:0] numx_q, numy_q, numz_q;
  logic [31:0]        den_q;
  sign_t              sg_q [DivStages+1];

  assign sl = side_q[SqStages-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numx_q <= (NumBits'(sl.mx) << 30) + NumBits'(root[31:1]);
      numy_q <= (NumBits'(sl.my) << 30) + NumBits'(root[31:1]);
      numz_q <= (NumBits'(sl.mz) << 30) + NumBits'(root[31:1]);
      den_q  <= root;
      sg_q[0] <= '{nx: sl.nx, nz: sl.nz, diag: sl.diag};
      for (int k = 1; k <= DivStages; k++) sg_q[k] <= sg_q[k-1];
    end
  end

  logic [DivStages-1:0] qx, qy, qz;

  hsn_div u_div_x (.clk_i(clk_i), .en_i(en_i), .num_i(numx_q), .den_i(den_q), .quo_o(qx));
  hsn_div u_div_y (.clk_i(clk_i), .en_i(en_i), .num_i(numy_q), .den_i(den_q), .quo_o(qy));
  hsn_div u_div_z (.clk_i(clk_i), .en_i(en_i), .num_i(numz_q), .den_i(den_q), .quo_o(qz));

  // weight and restore signs
  sign_t       sg;
  logic [13:0] wt;
  logic [44:0] px, py, pz;

  assign sg = sg_q[DivStages];
  assign wt = sg.diag ? WDiag : WCard;
  assign px = qx * wt;
  assign py = qy * wt;
  assign pz = qz * wt;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_o.w[0] <= sg.nx ? -$signed(46'(px)) : $signed(46'(px));
      lane_o.w[1] <= $signed(46'(py));
      lane_o.w[2] <= sg.nz ? -$signed(46'(pz)) : $signed(46'(pz));
      lane_o.u[0] <= sg.nx ? -$signed(32'(qx)) : $signed(32'(qx));
      lane_o.u[1] <= $signed(32'(qy));
      lane_o.u[2] <= sg.nz ? -$signed(32'(qz)) : $signed(32'(qz));
    end
  end

endmodule

[rtl/hsn_merge.sv]
// ----------------------------------------------------------------------------
// hsn_merge
// Adds the weighted lane normals and rounds to Q2.14, or passes the border
// unit vector of lane zero.
// ----------------------------------------------------------------------------
module hsn_merge
  import hsn_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic             at_edge_i,
  input  lane_out_t        lanes_i [NumLanes],
  output logic             valid_o,
  output logic [2:0][15:0] normal_o
);

  function automatic logic [15:0] from_sum(input logic signed [48:0] v);
    logic [48:0] m;
    logic [16:0] r;
    m = v[48] ? 49'(-v) : 49'(v);
    r = 17'((m + 49'(64'h8000_0000)) >> 32);
    if (r > 17'd16384) r = 17'd16384;
    return v[48] ? 16'(-r) : r[15:0];
  endfunction

  function automatic logic [15:0] from_unit(input logic signed [31:0] v);
    logic [31:0] m;
    logic [16:0] r;
    m = v[31] ? 32'(-v) : 32'(v);
    r = 17'((33'(m) + 33'h8000) >> 16);
    if (r > 17'd16384) r = 17'd16384;
    return v[31] ? 16'(-r) : r[15:0];
  endfunction

  logic signed [2:0][46:0] s1_q [4];
  logic signed [2:0][47:0] s2_q [2];
  logic signed [2:0][48:0] s3_q;
  logic signed [2:0][31:0] u1_q, u2_q, u3_q;
  logic [3:0]              vld_q;
  logic [2:0]              edg_q;

  // element selects of a packed array are unsigned: extend them as signed
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 3; c++) begin
        for (int p = 0; p < 4; p++)
          s1_q[p][c] <= 47'($signed(lanes_i[2*p].w[c])) +
                        47'($signed(lanes_i[2*p+1].w[c]));
        for (int p = 0; p < 2; p++)
          s2_q[p][c] <= 48'($signed(s1_q[2*p][c])) + 48'($signed(s1_q[2*p+1][c]));
        s3_q[c] <= 49'($signed(s2_q[0][c])) + 49'($signed(s2_q[1][c]));
        normal_o[c] <= edg_q[2] ? from_unit(u3_q[c]) : from_sum(s3_q[c]);
      end
      u1_q  <= lanes_i[0].u;
      u2_q  <= u1_q;
      u3_q  <= u2_q;
      edg_q <= {edg_q[1:0], at_edge_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  assign valid_o = vld_q[3];

endmodule

[rtl/heightmap_surface_normal.sv]
// ----------------------------------------------------------------------------
// heightmap_surface_normal
// Surface normal of a 3x3 height window: eight weighted directional unit
// normals for interior cells, a central difference normal at the border.
//
//   channel | direction | handshake            | word
//   cfg     | in        | cfg_valid / ready    | vertical_scale (Q8.8)
//   in      | in        | in_valid / in_stall  | nine heights, at_edge
//   out     | out       | out_valid / out_stall| normal_x, normal_y, normal_z
//
// One word enters per cycle while in_stall is low. Each word passes through
// the 32-stage square root and 31-stage dividers of the eight lanes and
// the adder tree. Reset sets vertical_scale to 1.0 and empties the
// pipeline. An output stall freezes the whole pipeline once the skid
// register behind the output register is full; in_stall follows it.
// ----------------------------------------------------------------------------
module heightmap_surface_normal
  import hsn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_vertical_scale_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] h_center_i,
  input  logic [15:0] h_xplus_i,
  input  logic [15:0] h_xminus_i,
  input  logic [15:0] h_yplus_i,
  input  logic [15:0] h_yminus_i,
  input  logic [15:0] h_xplus_yplus_i,
  input  logic [15:0] h_xplus_yminus_i,
  input  logic [15:0] h_xminus_yplus_i,
  input  logic [15:0] h_xminus_yminus_i,
  input  logic        at_edge_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o
);

  function automatic logic signed [HeightBits:0] diff(input logic [15:0] a,
                                                      input logic [15:0] b);
    return $signed({1'b0, a}) - $signed({1'b0, b});
  endfunction

  logic [15:0] vscale_q;
  logic        en;
  logic        skid_valid_q;

  assign cfg_ready_o = 1'b1;
  assign en          = !skid_valid_q;
  assign in_stall_o  = skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vscale_q <= 16'd256;
    end else if (cfg_valid_i) begin
      vscale_q <= cfg_vertical_scale_i;
    end
  end

  // lane operands
  lane_in_t         lin [NumLanes];
  logic signed [HeightBits:0] dg [4];

  assign dg[0] = diff(h_center_i, h_xplus_yplus_i);
  assign dg[1] = diff(h_center_i, h_xplus_yminus_i);
  assign dg[2] = diff(h_center_i, h_xminus_yplus_i);
  assign dg[3] = diff(h_center_i, h_xminus_yminus_i);

  always_comb begin
    if (at_edge_i) begin
      lin[0] = '{dx: diff(h_xminus_i, h_xplus_i), dz: diff(h_yminus_i, h_yplus_i),
                 two: 1'b1, diag: 1'b0};
    end else begin
      lin[0] = '{dx: diff(h_center_i, h_xplus_i), dz: '0, two: 1'b0, diag: 1'b0};
    end
    lin[1] = '{dx: diff(h_xminus_i, h_center_i), dz: '0, two: 1'b0, diag: 1'b0};
    lin[2] = '{dx: '0, dz: diff(h_center_i, h_yplus_i), two: 1'b0, diag: 1'b0};
    lin[3] = '{dx: '0, dz: diff(h_yminus_i, h_center_i), two: 1'b0, diag: 1'b0};
    for (int k = 0; k < 4; k++)
      lin[4+k] = '{dx: dg[k], dz: dg[k], two: 1'b1, diag: 1'b1};
  end

  lane_out_t lout [NumLanes];

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    hsn_lane u_lane (
      .clk_i    (clk_i),
      .en_i     (en),
      .vscale_i (vscale_q),
      .lane_i   (lin[l]),
      .lane_o   (lout[l])
    );
  end

  // valid and border flag travel beside the lanes
  logic [LaneLat-1:0] vld_q;
  logic [LaneLat-1:0] edg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LaneLat-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) edg_q <= {edg_q[LaneLat-2:0], at_edge_i};
  end

  logic             p_valid;
  logic [2:0][15:0] p_normal;

  hsn_merge u_merge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (vld_q[LaneLat-1]),
    .at_edge_i (edg_q[LaneLat-1]),
    .lanes_i   (lout),
    .valid_o   (p_valid),
    .normal_o  (p_normal)
  );

  // output register with skid
  logic             out_valid_q;
  logic [2:0][15:0] out_q, skid_q;
  logic             out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_free) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (p_valid) begin
      if (out_free) out_valid_q <= 1'b1;
      else          skid_valid_q <= 1'b1;
    end else if (out_free) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_free) out_q <= skid_q;
    end else if (p_valid) begin
      if (out_free) out_q  <= p_normal;
      else          skid_q <= p_normal;
    end
  end

  assign out_valid_o = out_valid_q;
  assign normal_x_o  = out_q[0];
  assign normal_y_o  = out_q[1];
  assign normal_z_o  = out_q[2];

endmodule

[sim/heightmap_surface_normal_tb.sv]
// ----------------------------------------------------------------------------
// heightmap_surface_normal_tb
// Drives 3x3 height windows into the surface normal pipeline under several
// vertical scales and idling patterns, computes the expected Q2.14 normal
// of every accepted word and compares each output word in order.
// ----------------------------------------------------------------------------
module heightmap_surface_normal_tb
  import hsn_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [15:0] h [9];  // centre, x+, x-, y+, y-, x+y+, x+y-, x-y+, x-y-
    logic        at_edge;
  } window_t;

  typedef struct {
    logic [15:0] n [3];  // x, up, z
  } normal_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_vertical_scale_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] hw [9];
  logic        at_edge_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;

  initial for (int k = 0; k < 9; k++) hw[k] = '0;

  heightmap_surface_normal dut (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_vertical_scale_i,
    .in_valid_i, .in_stall_o,
    .h_center_i(hw[0]), .h_xplus_i(hw[1]), .h_xminus_i(hw[2]),
    .h_yplus_i(hw[3]), .h_yminus_i(hw[4]), .h_xplus_yplus_i(hw[5]),
    .h_xplus_yminus_i(hw[6]), .h_xminus_yplus_i(hw[7]),
    .h_xminus_yminus_i(hw[8]), .at_edge_i,
    .out_valid_o, .out_stall_i,
    .normal_x_o, .normal_y_o, .normal_z_o
  );

  initial forever #5 clk_i = ~clk_i;

  longint unsigned scale_q88 = 256;
  normal_t         normals_due[$];
  int              errors = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              hold_cycles = 0;

  // ---------------- normal predictor ----------------
  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned magn(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // unit vector in Q.30
  function automatic void unit_q30(input longint c [3], output longint u [3]);
    longint unsigned m [3];
    longint unsigned len;
    for (int k = 0; k < 3; k++) m[k] = magn(c[k]);
    while ((m[0] | m[1] | m[2]) >= (64'd1 << 31))
      for (int k = 0; k < 3; k++) m[k] >>= 1;
    len = root_floor(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
    for (int k = 0; k < 3; k++) begin
      if (len == 0) u[k] = 0;
      else begin
        u[k] = ((m[k] << 30) + len / 2) / len;
        if (c[k] < 0) u[k] = -u[k];
      end
    end
  endfunction

  function automatic logic [15:0] round_sat(longint v, int sh);
    longint unsigned m = (magn(v) + (64'd1 << (sh - 1))) >> sh;
    longint r;
    if (m > 16384) m = 16384;
    r = v < 0 ? -longint'(m) : longint'(m);
    return r[15:0];
  endfunction

  function automatic normal_t surface_normal(window_t w);
    longint h [9];
    longint c [3];
    longint u [3];
    longint acc [3];
    longint d;
    longint wt;
    normal_t r;
    for (int k = 0; k < 9; k++) h[k] = longint'(w.h[k]);
    acc = '{0, 0, 0};
    if (w.at_edge) begin
      c = '{(h[2] - h[1]) * longint'(scale_q88), 2 * 65536,
            (h[4] - h[3]) * longint'(scale_q88)};
      unit_q30(c, u);
      for (int k = 0; k < 3; k++) r.n[k] = round_sat(u[k], 16);
    end else begin
      for (int j = 0; j < 8; j++) begin
        case (j)
          0: c = '{(h[0] - h[1]) * longint'(scale_q88), 65536, 0};
          1: c = '{(h[2] - h[0]) * longint'(scale_q88), 65536, 0};
          2: c = '{0, 65536, (h[0] - h[3]) * longint'(scale_q88)};
          3: c = '{0, 65536, (h[4] - h[0]) * longint'(scale_q88)};
          default: begin
            d = (h[0] - h[j + 1]) * longint'(scale_q88);
            c = '{d, 2 * 65536, d};
          end
        endcase
        wt = j < 4 ? longint'(WCard) : longint'(WDiag);
        unit_q30(c, u);
        for (int k = 0; k < 3; k++) acc[k] += u[k] * wt;
      end
      for (int k = 0; k < 3; k++) r.n[k] = round_sat(acc[k], 32);
    end
    return r;
  endfunction

  // ---------------- receiver and checker ----------------
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= $urandom_range(99) < recv_stall_pct;
    end
  end

  always @(posedge clk_i) begin
    normal_t want;
    logic [15:0] got [3];
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{normal_x_o, normal_y_o, normal_z_o};
      if (normals_due.size() == 0) begin
        $display("%0t: unexpected word x=%0d y=%0d z=%0d", $time,
                 $signed(got[0]), $signed(got[1]), $signed(got[2]));
        errors++;
      end else begin
        want = normals_due.pop_front();
        for (int k = 0; k < 3; k++)
          if (got[k] !== want.n[k]) begin
            $display("%0t: component %0d expected %0d actual %0d", $time, k,
                     $signed(want.n[k]), $signed(got[k]));
            errors++;
          end
      end
    end
  end

  // ---------------- driver ----------------
  task automatic send_window(window_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int k = 0; k < 9; k++) hw[k] <= w.h[k];
    at_edge_i <= w.at_edge;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    normals_due.push_back(surface_normal(w));
  endtask

  // wait for the pipeline to drain, then write the scale
  task automatic write_scale(logic [15:0] s);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (LaneLat + 10) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_vertical_scale_i <= s;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    scale_q88 = s;
  endtask

  function automatic window_t rand_window(logic edge_flag);
    window_t w;
    int spread;
    w.at_edge = edge_flag;
    w.h[0] = $urandom;
    // mostly gentle terrain around the centre, sometimes anything
    spread = $urandom_range(3) == 0 ? 65535 : (1 << $urandom_range(12));
    for (int k = 1; k < 9; k++)
      if (spread == 65535) w.h[k] = $urandom;
      else w.h[k] = w.h[0] + $urandom_range(2 * spread) - spread;
    return w;
  endfunction

  function automatic window_t flat_window(logic [15:0] c, logic edge_flag);
    window_t w;
    w.at_edge = edge_flag;
    for (int k = 0; k < 9; k++) w.h[k] = c;
    return w;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    window_t w;
    logic [15:0] scales [3] = '{16'd256, 16'd65535, 16'd0};
    foreach (scales[s]) begin
      write_scale(scales[s]);
      for (int e = 0; e < 2; e++) begin
        send_window(flat_window(16'h0000, e));
        send_window(flat_window(16'hFFFF, e));
        // steepest slopes: centre high, neighbours low and the reverse
        w = flat_window(16'h0000, e);
        w.h[0] = 16'hFFFF;
        send_window(w);
        w = flat_window(16'hFFFF, e);
        w.h[0] = 16'h0000;
        send_window(w);
        // opposite extremes on each axis
        w = flat_window(16'h8000, e);
        w.h[1] = 16'hFFFF; w.h[2] = 16'h0000; w.h[3] = 16'h0000; w.h[4] = 16'hFFFF;
        w.h[5] = 16'h0000; w.h[8] = 16'hFFFF;
        send_window(w);
      end
    end
  endtask

  task automatic test_random(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    write_scale($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(512)));
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) write_scale($urandom_range(1) ? 16'd65535 : 16'($urandom_range(64)));
      send_window(rand_window($urandom_range(3) == 0));
    end
  endtask

  // long output hold while words keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_scale(16'd256);
    hold_cycles = 300;
    for (int i = 0; i < 150; i++) send_window(rand_window($urandom_range(1)));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // reset value of the scale first
    send_window(rand_window(1'b0));
    send_window(rand_window(1'b1));
    test_directed();
    test_random(225, 8, 67);
    test_random(225, 67, 8);
    test_random(225, 0, 0);
    test_backpressure();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (normals_due.size() != 0) @(posedge clk_i);
    repeat (LaneLat + 20) @(posedge clk_i);
    if (errors == 0) $display("heightmap_surface_normal_tb: done, clean");
    else $display("heightmap_surface_normal_tb: done, errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("heightmap_surface_normal_tb: done, errors");
    $finish;
  end

endmodule
